/* sv/swva_pkg.sv */
// ----------------------------------------------------------------------------
// swva_pkg
// Shared types and constants of the sliding-window VWAP accumulator.
// ----------------------------------------------------------------------------
package swva_pkg;

  // Trade store depth and derived pointer and count widths
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned PTR_W    = $clog2(CAPACITY);
  localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned PV_W    = 63;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned WIN_W   = 17;
  localparam int unsigned SPAN_W  = 47;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned MUL_W   = 32;

  // Nanoseconds per second, as a multiplier operand
  localparam logic [MUL_W-1:0] NS_PER_SEC = 32'd1_000_000_000;

  // Register file
  localparam int unsigned      ADDR_W           = 3;
  localparam int unsigned      DATA_W           = 32;
  localparam logic             REG_WINDOW_IDX   = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET_VAL = 17'd60;

  // One stored trade
  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [QTY_W-1:0]  qty;
    logic [PV_W-1:0]   pv;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_INVALID      = 3'd1,
    ST_OUT_OF_ORDER = 3'd2,
    ST_OVERFLOW     = 3'd3,
    ST_FULL         = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN,
    S_PV,
    S_CHECK,
    S_PUSH,
    S_READ,
    S_CMP,
    S_FLAG,
    S_FIN
  } state_e;

endpackage

/* sv/swva_ram.sv */
// ----------------------------------------------------------------------------
// swva_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sliding_window_vwap_accumulator_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_vwap_accumulator_top
// Time-windowed volume and price-volume accumulator over a trade FIFO.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  in        in_valid_i / in_stall_o    trade_time_i, trade_price_i, trade_quantity_i
//  out       out_valid_o / out_stall_i  status_o, sums, window_count_o, flag, totals
//  cfg       APB psel/penable/pwrite    paddr, pwdata, prdata (window_seconds)
//
// A rejected item passes S_SPAN, S_PV, S_CHECK and S_FIN before the next accept.
// An accepted item passes S_SPAN, S_PV, S_CHECK, S_PUSH, one S_READ/S_CMP pair
// per expired entry popped, a last S_READ (plus S_CMP if entries remain), S_FLAG
// and S_FIN: every pop is one read and one compare of the registered-read entry RAM.
// One 32x32 multiplier serves both the window span and price*quantity.
// Reset clears all sums, pointers and counters at once; the store needs no
// clearing pass. A stalled result sits in the output register while the
// next item is already being worked on.
// ----------------------------------------------------------------------------
module sliding_window_vwap_accumulator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // trade items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [swva_pkg::TIME_W-1:0]        trade_time_i,
  input  logic signed [swva_pkg::PRICE_W-1:0] trade_price_i,
  input  logic [swva_pkg::QTY_W-1:0]         trade_quantity_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [swva_pkg::SUM_W-1:0]         volume_sum_o,
  output logic [swva_pkg::SUM_W-1:0]         price_volume_sum_o,
  output logic [swva_pkg::OCC_W-1:0]         window_count_o,
  output logic                               window_complete_o,
  output logic [swva_pkg::CNT_W-1:0]         accepted_total_o,
  output logic [swva_pkg::CNT_W-1:0]         rejected_total_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swva_pkg::ADDR_W-1:0]        paddr,
  input  logic [swva_pkg::DATA_W-1:0]        pwdata,
  output logic [swva_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam logic [swva_pkg::PTR_W:0]   CAP_PTR = (swva_pkg::PTR_W + 1)'(swva_pkg::CAPACITY);
  localparam logic [swva_pkg::OCC_W-1:0] CAP_OCC = swva_pkg::OCC_W'(swva_pkg::CAPACITY);
  localparam logic [swva_pkg::PTR_W-1:0] PTR_LAST =
    swva_pkg::PTR_W'(swva_pkg::CAPACITY - 1);

  // Sequencer
  swva_pkg::state_e state_q, state_d;

  // Architectural state
  logic [swva_pkg::PTR_W-1:0]  head_q, head_d;
  logic [swva_pkg::OCC_W-1:0]  occ_q, occ_d;
  logic [swva_pkg::SUM_W-1:0]  vol_q, vol_d;
  logic [swva_pkg::SUM_W-1:0]  pvsum_q, pvsum_d;
  logic [swva_pkg::TIME_W-1:0] prev_q, prev_d;
  logic [swva_pkg::TIME_W-1:0] wstart_q, wstart_d;
  logic                        flag_q, flag_d;
  logic [swva_pkg::CNT_W-1:0]  acc_q, acc_d;
  logic [swva_pkg::CNT_W-1:0]  rej_q, rej_d;
  logic [swva_pkg::WIN_W-1:0]  win_q, win_d;
  logic                        popped_q, popped_d;
  logic                        out_valid_q, out_valid_d;

  // Per-item working registers
  logic [swva_pkg::TIME_W-1:0]  t_q;
  logic [swva_pkg::PRICE_W-1:0] price_q;
  logic [swva_pkg::QTY_W-1:0]   qty_q;
  logic [swva_pkg::SPAN_W-1:0]  span_q, span_d;
  logic [swva_pkg::PV_W-1:0]    pv_q, pv_d;
  logic [swva_pkg::TIME_W-1:0]  cutoff_q, cutoff_d;
  swva_pkg::status_e            status_q, status_d;

  // Output register payload
  logic [2:0]                  o_status_q;
  logic [swva_pkg::SUM_W-1:0]  o_vol_q, o_pvsum_q;
  logic [swva_pkg::OCC_W-1:0]  o_occ_q;
  logic                        o_flag_q;
  logic [swva_pkg::CNT_W-1:0]  o_acc_q, o_rej_q;

  // Shared multiplier
  logic [swva_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*swva_pkg::MUL_W-1:0] product;

  // Entry RAM ports
  logic                        ram_we, ram_re;
  logic [swva_pkg::PTR_W-1:0]  ram_waddr, ram_raddr;
  swva_pkg::entry_t            ram_wdata, ram_rdata;

  // Misc datapath
  logic                        in_accept, out_take, out_load, cfg_write;
  logic [swva_pkg::TIME_W-1:0] span64;
  logic [swva_pkg::PTR_W:0]    tail_sum;
  logic [swva_pkg::PTR_W-1:0]  tail_ptr, head_inc;
  logic [swva_pkg::SUM_W:0]    vol_ext, pvsum_ext;
  logic [swva_pkg::TIME_W-1:0] elapsed;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign out_load  = (state_q == swva_pkg::S_FIN) && (!out_valid_q || !out_stall_i);
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[swva_pkg::ADDR_W-1:2] == swva_pkg::REG_WINDOW_IDX);

  // Multiplier operand select: span first, then price times quantity
  always_comb begin
    case (state_q)
      swva_pkg::S_SPAN: begin
        mul_a = swva_pkg::MUL_W'(win_q);
        mul_b = swva_pkg::NS_PER_SEC;
      end
      swva_pkg::S_PV: begin
        mul_a = {1'b0, price_q[swva_pkg::PRICE_W-2:0]};
        mul_b = qty_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = (2 * swva_pkg::MUL_W)'(mul_a) * (2 * swva_pkg::MUL_W)'(mul_b);

  // FIFO pointer arithmetic
  assign span64   = swva_pkg::TIME_W'(span_q);
  assign tail_sum = (swva_pkg::PTR_W + 1)'(head_q) + (swva_pkg::PTR_W + 1)'(occ_q);
  assign tail_ptr = (tail_sum >= CAP_PTR) ? swva_pkg::PTR_W'(tail_sum - CAP_PTR)
                                          : tail_sum[swva_pkg::PTR_W-1:0];
  assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;

  // Sums with carry for the overflow check
  assign vol_ext   = {1'b0, vol_q} + (swva_pkg::SUM_W + 1)'(qty_q);
  assign pvsum_ext = {1'b0, pvsum_q} + (swva_pkg::SUM_W + 1)'(pv_q);
  assign elapsed   = t_q - wstart_q;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      swva_pkg::S_IDLE:  if (in_valid_i) state_d = swva_pkg::S_SPAN;
      swva_pkg::S_SPAN:  state_d = swva_pkg::S_PV;
      swva_pkg::S_PV:    state_d = swva_pkg::S_CHECK;
      swva_pkg::S_CHECK: begin
        if (status_d == swva_pkg::ST_ACCEPTED) state_d = swva_pkg::S_PUSH;
        else                                   state_d = swva_pkg::S_FIN;
      end
      swva_pkg::S_PUSH:  state_d = swva_pkg::S_READ;
      swva_pkg::S_READ: begin
        if (occ_q == '0) state_d = swva_pkg::S_FLAG;
        else             state_d = swva_pkg::S_CMP;
      end
      swva_pkg::S_CMP: begin
        if (ram_rdata.ts < cutoff_q) state_d = swva_pkg::S_READ;
        else                         state_d = swva_pkg::S_FLAG;
      end
      swva_pkg::S_FLAG:  state_d = swva_pkg::S_FIN;
      swva_pkg::S_FIN:   if (out_load) state_d = swva_pkg::S_IDLE;
      default:           state_d = swva_pkg::S_IDLE;
    endcase
  end

  // Datapath and output logic
  always_comb begin
    head_d      = head_q;
    occ_d       = occ_q;
    vol_d       = vol_q;
    pvsum_d     = pvsum_q;
    prev_d      = prev_q;
    wstart_d    = wstart_q;
    flag_d      = flag_q;
    acc_d       = acc_q;
    rej_d       = rej_q;
    popped_d    = popped_q;
    span_d      = span_q;
    pv_d        = pv_q;
    cutoff_d    = cutoff_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_ptr;
    ram_raddr   = head_q;
    ram_wdata   = '{ts: t_q, qty: qty_q, pv: pv_q};
    case (state_q)
      swva_pkg::S_SPAN: begin
        span_d = product[swva_pkg::SPAN_W-1:0];
      end
      swva_pkg::S_PV: begin
        pv_d     = product[swva_pkg::PV_W-1:0];
        cutoff_d = (t_q > span64) ? t_q - span64 : '0;
      end
      // Rejection checks in priority order
      swva_pkg::S_CHECK: begin
        if (price_q[swva_pkg::PRICE_W-1] || (qty_q == '0)) begin
          status_d = swva_pkg::ST_INVALID;
        end else if ((prev_q != '0) && (t_q < prev_q)) begin
          status_d = swva_pkg::ST_OUT_OF_ORDER;
        end else if (pvsum_ext[swva_pkg::SUM_W] || vol_ext[swva_pkg::SUM_W]) begin
          status_d = swva_pkg::ST_OVERFLOW;
        end else if (occ_q >= CAP_OCC) begin
          status_d = swva_pkg::ST_FULL;
        end else begin
          status_d = swva_pkg::ST_ACCEPTED;
        end
        if ((status_d != swva_pkg::ST_ACCEPTED) && !(&rej_q)) begin
          rej_d = rej_q + 1'b1;
        end
      end
      // Append at the tail and grow the sums
      swva_pkg::S_PUSH: begin
        ram_we   = 1'b1;
        occ_d    = occ_q + 1'b1;
        vol_d    = vol_ext[swva_pkg::SUM_W-1:0];
        pvsum_d  = pvsum_ext[swva_pkg::SUM_W-1:0];
        prev_d   = t_q;
        popped_d = 1'b0;
        if (wstart_q == '0) wstart_d = t_q;
        if (!(&acc_q)) acc_d = acc_q + 1'b1;
      end
      // Fetch the head, or clear out an emptied window
      swva_pkg::S_READ: begin
        if (occ_q == '0) begin
          if (popped_q) begin
            vol_d    = '0;
            pvsum_d  = '0;
            wstart_d = '0;
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      // Pop an expired head, else settle the window start
      swva_pkg::S_CMP: begin
        if (ram_rdata.ts < cutoff_q) begin
          vol_d    = vol_q - swva_pkg::SUM_W'(ram_rdata.qty);
          pvsum_d  = pvsum_q - swva_pkg::SUM_W'(ram_rdata.pv);
          head_d   = head_inc;
          occ_d    = occ_q - 1'b1;
          popped_d = 1'b1;
        end else if (popped_q) begin
          wstart_d = ram_rdata.ts;
        end
      end
      swva_pkg::S_FLAG: begin
        if (elapsed >= span64) flag_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)      out_valid_d = 1'b1;
    else if (out_take) out_valid_d = 1'b0;
  end

  // Configuration register
  always_comb begin
    win_d = win_q;
    if (cfg_write) win_d = pwdata[swva_pkg::WIN_W-1:0];
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swva_pkg::S_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      vol_q       <= '0;
      pvsum_q     <= '0;
      prev_q      <= '0;
      wstart_q    <= '0;
      flag_q      <= 1'b0;
      acc_q       <= '0;
      rej_q       <= '0;
      win_q       <= swva_pkg::WINDOW_RESET_VAL;
      popped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      vol_q       <= vol_d;
      pvsum_q     <= pvsum_d;
      prev_q      <= prev_d;
      wstart_q    <= wstart_d;
      flag_q      <= flag_d;
      acc_q       <= acc_d;
      rej_q       <= rej_d;
      win_q       <= win_d;
      popped_q    <= popped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload and working values
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      t_q     <= trade_time_i;
      price_q <= trade_price_i;
      qty_q   <= trade_quantity_i;
    end
    span_q   <= span_d;
    pv_q     <= pv_d;
    cutoff_q <= cutoff_d;
    status_q <= status_d;
    if (out_load) begin
      o_status_q <= status_q;
      o_vol_q    <= vol_q;
      o_pvsum_q  <= pvsum_q;
      o_occ_q    <= occ_q;
      o_flag_q   <= flag_q;
      o_acc_q    <= acc_q;
      o_rej_q    <= rej_q;
    end
  end

  // Trade store
  swva_ram #(
    .WIDTH (swva_pkg::ENTRY_W),
    .DEPTH (swva_pkg::CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o         = (state_q != swva_pkg::S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = o_status_q;
  assign volume_sum_o       = o_vol_q;
  assign price_volume_sum_o = o_pvsum_q;
  assign window_count_o     = o_occ_q;
  assign window_complete_o  = o_flag_q;
  assign accepted_total_o   = o_acc_q;
  assign rejected_total_o   = o_rej_q;

  assign pready = 1'b1;
  assign prdata = (paddr[swva_pkg::ADDR_W-1:2] == swva_pkg::REG_WINDOW_IDX)
                  ? swva_pkg::DATA_W'(win_q) : '0;

endmodule

/* sv/swva_checker.sv */
// ----------------------------------------------------------------------------
// swva_checker
// Port-level checks of the VWAP accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module swva_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [2:0]                  status_o,
  input logic [swva_pkg::SUM_W-1:0]  volume_sum_o,
  input logic [swva_pkg::SUM_W-1:0]  price_volume_sum_o,
  input logic [swva_pkg::OCC_W-1:0]  window_count_o
);

  // A stalled result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken during work");

  // Occupancy never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_count_o <= swva_pkg::OCC_W'(swva_pkg::CAPACITY))
    else $error("window count above capacity");

  // An empty window carries zero sums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (window_count_o == '0)
      |-> (volume_sum_o == '0) && (price_volume_sum_o == '0))
    else $error("nonzero sums with empty window");

  // Status code is a defined one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= swva_pkg::ST_FULL)
    else $error("undefined status code");

endmodule

bind sliding_window_vwap_accumulator_top swva_checker u_swva_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_o           (status_o),
  .volume_sum_o       (volume_sum_o),
  .price_volume_sum_o (price_volume_sum_o),
  .window_count_o     (window_count_o)
);
